// ===== sv/octave_value_noise_2d_unit_assert.svh =====
// Assertion macros for the checker of the noise unit.
// Each macro expands to one labeled concurrent assertion clocked on clk_i.
`ifndef OCTAVE_VALUE_NOISE_2D_UNIT_ASSERT_SVH
`define OCTAVE_VALUE_NOISE_2D_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define OVN_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("noise unit assertion failed");

// next-cycle implication, disabled during reset
`define OVN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("noise unit assertion failed");

`endif

// ===== sv/ovn_pkg.sv =====
// Shared types and constants of the octave value noise unit.
// No dependencies; imported by the front end, queue, back end, top level and checker.
`default_nettype none

package ovn_pkg;

  // grid geometry
  localparam int SIDE_LOG2   = 8;
  localparam int COORD_W     = 8;
  localparam int SEED_W      = 16;
  localparam int ADDR_W      = 2 * SIDE_LOG2;
  localparam int STORE_DEPTH = 1 << ADDR_W;

  // configuration port
  localparam int OCT_W      = 4;
  localparam int BIAS_W     = 12;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_OCT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BIAS = CFG_IDX_W'(1);
  localparam logic [OCT_W-1:0]  OCT_RESET  = OCT_W'(1);
  localparam logic [BIAS_W-1:0] BIAS_RESET = BIAS_W'(512);
  localparam logic [BIAS_W-1:0] BIAS_MIN   = BIAS_W'(51);
  localparam logic [BIAS_W-1:0] BIAS_MAX   = BIAS_W'(2560);

  // octave loop
  localparam int OCT_HW    = 8;
  localparam int OCT_MAX   = (SIDE_LOG2 < OCT_HW) ? SIDE_LOG2 : OCT_HW;
  localparam int OCT_IDX_W = $clog2(OCT_HW);
  localparam int SH_W      = $clog2(SIDE_LOG2 + 1);
  localparam int PITCH_W   = SIDE_LOG2 + 1;
  localparam int CW_W      = 2 * PITCH_W;
  localparam int NUM_W     = CW_W + SEED_W;

  // octave weights, unsigned Q17.24 (largest weight stays below 2^41)
  localparam int W_FRAC  = 24;
  localparam int W_W     = 41;
  localparam int W_LO_W  = W_FRAC;
  localparam int W_HI_W  = W_W - W_LO_W;
  localparam int W_SHIFT = 8;
  localparam int DVD_W   = W_W + W_SHIFT;
  localparam logic [W_W-1:0] W_ONE = {{(W_W-W_FRAC-1){1'b0}}, 1'b1, {W_FRAC{1'b0}}};

  // result path
  localparam int NOISE_W = 16;
  localparam int ACC_W   = 60;
  localparam int WSUM_W  = 44;

  // item queue
  localparam int FIFO_DEPTH = 2;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_e;

  // one classified item in the queue
  typedef struct packed {
    req_e                  kind;
    logic [SIDE_LOG2-1:0]  x;
    logic [SIDE_LOG2-1:0]  y;
    logic [SEED_W-1:0]     seed;
  } item_t;

  // clamped configuration seen by the back end
  typedef struct packed {
    logic [OCT_W-1:0]  oct_n;
    logic [BIAS_W-1:0] bias;
    logic              bias_wr;
  } cfg_t;

  // seed store access from the back end
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [SEED_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

// ===== sv/ovn_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; used for the seed store.
`default_nettype none

module ovn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/ovn_front.sv =====
// Front end: input handshake, item classification, configuration registers.
// Depends on ovn_pkg.
`default_nettype none

module ovn_front import ovn_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  req_type_i,
  input  logic [COORD_W-1:0]    coord_x_i,
  input  logic [COORD_W-1:0]    coord_y_i,
  input  logic [SEED_W-1:0]     seed_value_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  full_i,
  output logic                  push_o,
  output item_t                 item_o,
  output cfg_t                  cfg_o
);

  logic [OCT_W-1:0]  oct_q;
  logic [BIAS_W-1:0] bias_q;
  logic              wr_oct;
  logic              wr_bias;

  // register writes; unknown indexes fall through
  assign wr_oct  = cfg_we_i && (cfg_idx_i == CFG_IDX_OCT);
  assign wr_bias = cfg_we_i && (cfg_idx_i == CFG_IDX_BIAS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_q  <= OCT_RESET;
      bias_q <= BIAS_RESET;
    end else begin
      if (wr_oct) begin
        oct_q <= cfg_wdata_i[OCT_W-1:0];
      end
      if (wr_bias) begin
        bias_q <= cfg_wdata_i[BIAS_W-1:0];
      end
    end
  end

  // saturate both registers into their legal ranges
  always_comb begin
    if (oct_q == '0) begin
      cfg_o.oct_n = OCT_W'(1);
    end else if (oct_q > OCT_W'(OCT_MAX)) begin
      cfg_o.oct_n = OCT_W'(OCT_MAX);
    end else begin
      cfg_o.oct_n = oct_q;
    end
    if (bias_q < BIAS_MIN) begin
      cfg_o.bias = BIAS_MIN;
    end else if (bias_q > BIAS_MAX) begin
      cfg_o.bias = BIAS_MAX;
    end else begin
      cfg_o.bias = bias_q;
    end
    cfg_o.bias_wr = wr_bias;
  end

  // classify and push into the queue; coordinates wrap to the grid
  assign in_stall_o  = full_i;
  assign push_o      = in_valid_i && !full_i;
  assign item_o.kind = req_e'(req_type_i);
  assign item_o.x    = coord_x_i[SIDE_LOG2-1:0];
  assign item_o.y    = coord_y_i[SIDE_LOG2-1:0];
  assign item_o.seed = seed_value_i;

endmodule

`default_nettype wire

// ===== sv/ovn_fifo.sv =====
// Short item queue between the front end and the back end.
// Depends on ovn_pkg (item_t, FIFO_DEPTH).
`default_nettype none

module ovn_fifo import ovn_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output item_t head_o,
  output logic  full_o,
  output logic  empty_o
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  item_t            store_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = store_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ovn_back.sv =====
// Back end: seed writes, weight table, octave interpolation, final division.
// Depends on ovn_pkg; drives the seed store RAM through a ram_req_t.
`default_nettype none

module ovn_back import ovn_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  item_t              head_i,
  output logic               pop_o,
  input  cfg_t               cfg_i,
  output ram_req_t           ram_o,
  input  logic [SEED_W-1:0]  rdata_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [NOISE_W-1:0] noise_value_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WGT,
    ST_OCT,
    ST_DIV,
    ST_OUT
  } state_e;

  localparam int PH_W   = 4;
  localparam int BIT_W  = $clog2(DVD_W);
  localparam int QCNT_W = $clog2(NOISE_W);
  localparam int PLO_W  = NOISE_W + W_LO_W;
  localparam int PHI_W  = NOISE_W + W_HI_W;

  // octave sequence phases
  localparam logic [PH_W-1:0] PH_ISSUE_LAST = PH_W'(3);
  localparam logic [PH_W-1:0] PH_PROD_FIRST = PH_W'(1);
  localparam logic [PH_W-1:0] PH_PROD_LAST  = PH_W'(4);
  localparam logic [PH_W-1:0] PH_ADD_FIRST  = PH_W'(2);
  localparam logic [PH_W-1:0] PH_ADD_LAST   = PH_W'(5);
  localparam logic [PH_W-1:0] PH_VAL        = PH_W'(6);
  localparam logic [PH_W-1:0] PH_LO         = PH_W'(7);
  localparam logic [PH_W-1:0] PH_HI         = PH_W'(8);
  localparam logic [PH_W-1:0] PH_SUM        = PH_W'(9);

  state_e               state_q;
  logic [SIDE_LOG2-1:0] x_q;
  logic [SIDE_LOG2-1:0] y_q;
  logic [OCT_IDX_W-1:0] j_q;
  logic [PH_W-1:0]      ph_q;
  logic [OCT_IDX_W-1:0] k_q;
  logic [BIT_W-1:0]     bit_q;
  logic [DVD_W-1:0]     dvd_q;
  logic [BIAS_W-1:0]    wrem_q;
  logic [DVD_W-1:0]     quo_q;
  logic [W_W-1:0]       wtab_q [OCT_HW];
  logic                 wvalid_q;
  logic [CW_W-1:0]      cw_q;
  logic [NUM_W-1:0]     prod_q;
  logic [NUM_W-1:0]     num_q;
  logic [NOISE_W-1:0]   val_q;
  logic [PLO_W-1:0]     plo_q;
  logic [PHI_W-1:0]     phi_q;
  logic [ACC_W-1:0]     acc_q;
  logic [WSUM_W-1:0]    wsum_q;
  logic [ACC_W-1:0]     rem_q;
  logic [ACC_W-1:0]     dsr_q;
  logic [NOISE_W-1:0]   qt_q;
  logic [QCNT_W-1:0]    cnt_q;
  logic                 out_valid_q;
  logic [NOISE_W-1:0]   noise_q;

  logic [SH_W-1:0]      sh;
  logic [PITCH_W-1:0]   pitch;
  logic [PITCH_W-1:0]   pm1;
  logic [SIDE_LOG2-1:0] fmask;
  logic [SIDE_LOG2-1:0] fx, fy, x1, y1, x2, y2, cx, cy;
  logic [PITCH_W-1:0]   wx_near, wy_near, wx_far, wy_far;
  logic [1:0]           corner;
  logic [CW_W-1:0]      cw;
  logic [NUM_W-1:0]     num_sh;
  logic [W_W-1:0]       wcur;
  logic [ACC_W-1:0]     acc_new;
  logic [WSUM_W-1:0]    wsum_new;
  logic                 oct_last;
  logic [BIAS_W:0]      wrem_sh;
  logic                 wfit;
  logic [BIAS_W:0]      wrem_nx;
  logic [DVD_W-1:0]     quo_nx;
  logic                 qfit;

  // cell geometry for the current octave
  always_comb begin
    sh      = SH_W'(SIDE_LOG2) - SH_W'(j_q);
    pitch   = PITCH_W'(1) << sh;
    pm1     = pitch - PITCH_W'(1);
    fmask   = pm1[SIDE_LOG2-1:0];
    fx      = x_q & fmask;
    fy      = y_q & fmask;
    x1      = x_q & ~fmask;
    y1      = y_q & ~fmask;
    x2      = x1 + pitch[SIDE_LOG2-1:0];
    y2      = y1 + pitch[SIDE_LOG2-1:0];
    wx_near = pitch - PITCH_W'(fx);
    wy_near = pitch - PITCH_W'(fy);
    wx_far  = PITCH_W'(fx);
    wy_far  = PITCH_W'(fy);
    corner  = ph_q[1:0];
    cx      = corner[0] ? x2 : x1;
    cy      = corner[1] ? y2 : y1;
    cw      = CW_W'(corner[0] ? wx_far : wx_near) * CW_W'(corner[1] ? wy_far : wy_near);
    num_sh  = num_q >> {sh, 1'b0};
  end

  // weighting and accumulation
  assign wcur     = wtab_q[j_q];
  assign acc_new  = acc_q + ACC_W'({phi_q, {W_LO_W{1'b0}}});
  assign wsum_new = wsum_q + WSUM_W'(wcur);
  assign oct_last = (OCT_W'(j_q) + OCT_W'(1)) == cfg_i.oct_n;

  // one bit of the weight division w * 256 / bias
  assign wrem_sh = {wrem_q, dvd_q[DVD_W-1]};
  assign wfit    = wrem_sh >= {1'b0, cfg_i.bias};
  assign wrem_nx = wfit ? wrem_sh - {1'b0, cfg_i.bias} : wrem_sh;
  assign quo_nx  = {quo_q[DVD_W-2:0], wfit};

  // one bit of the final normalizing division
  assign qfit = rem_q >= dsr_q;

  // queue and seed store access
  assign pop_o       = (state_q == ST_IDLE) && !empty_i;
  assign ram_o.we    = pop_o && (head_i.kind == REQ_WRITE);
  assign ram_o.waddr = {head_i.y, head_i.x};
  assign ram_o.wdata = head_i.seed;
  assign ram_o.raddr = {cy, cx};

  assign out_valid_o   = out_valid_q;
  assign noise_value_o = noise_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_q         <= '0;
      y_q         <= '0;
      j_q         <= '0;
      ph_q        <= '0;
      k_q         <= '0;
      bit_q       <= '0;
      dvd_q       <= '0;
      wrem_q      <= '0;
      quo_q       <= '0;
      for (int i = 0; i < OCT_HW; i++) begin
        wtab_q[i] <= '0;
      end
      wvalid_q    <= 1'b0;
      cw_q        <= '0;
      prod_q      <= '0;
      num_q       <= '0;
      val_q       <= '0;
      plo_q       <= '0;
      phi_q       <= '0;
      acc_q       <= '0;
      wsum_q      <= '0;
      rem_q       <= '0;
      dsr_q       <= '0;
      qt_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      noise_q     <= '0;
    end else begin
      // result taken by the receiver
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // a new bias makes the weight table stale
      if (cfg_i.bias_wr) begin
        wvalid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (!empty_i && (head_i.kind == REQ_QUERY)) begin
            x_q    <= head_i.x;
            y_q    <= head_i.y;
            j_q    <= '0;
            ph_q   <= '0;
            acc_q  <= '0;
            wsum_q <= '0;
            if (wvalid_q) begin
              state_q <= ST_OCT;
            end else begin
              state_q   <= ST_WGT;
              wtab_q[0] <= W_ONE;
              k_q       <= OCT_IDX_W'(1);
              bit_q     <= '0;
              wrem_q    <= '0;
              quo_q     <= '0;
              dvd_q     <= {W_ONE, {W_SHIFT{1'b0}}};
            end
          end
        end

        // rebuild the weight table, one quotient bit per cycle
        ST_WGT: begin
          dvd_q  <= dvd_q << 1;
          wrem_q <= wrem_nx[BIAS_W-1:0];
          quo_q  <= quo_nx;
          bit_q  <= bit_q + BIT_W'(1);
          if (bit_q == BIT_W'(DVD_W - 1)) begin
            wtab_q[k_q] <= quo_nx[W_W-1:0];
            bit_q       <= '0;
            wrem_q      <= '0;
            quo_q       <= '0;
            dvd_q       <= {quo_nx[W_W-1:0], {W_SHIFT{1'b0}}};
            if (k_q == OCT_IDX_W'(OCT_HW - 1)) begin
              wvalid_q <= 1'b1;
              state_q  <= ST_OCT;
            end else begin
              k_q <= k_q + OCT_IDX_W'(1);
            end
          end
        end

        // one octave: four corner reads, bilinear sum, weighting
        ST_OCT: begin
          ph_q <= ph_q + PH_W'(1);
          if (ph_q <= PH_ISSUE_LAST) begin
            cw_q <= cw;
          end
          if (ph_q == '0) begin
            num_q <= '0;
          end
          if ((ph_q >= PH_PROD_FIRST) && (ph_q <= PH_PROD_LAST)) begin
            prod_q <= NUM_W'(rdata_i) * NUM_W'(cw_q);
          end
          if ((ph_q >= PH_ADD_FIRST) && (ph_q <= PH_ADD_LAST)) begin
            num_q <= num_q + prod_q;
          end
          case (ph_q)
            PH_VAL: val_q <= num_sh[NOISE_W-1:0];
            PH_LO:  plo_q <= PLO_W'(val_q) * PLO_W'(wcur[W_LO_W-1:0]);
            PH_HI: begin
              phi_q <= PHI_W'(val_q) * PHI_W'(wcur[W_W-1:W_LO_W]);
              acc_q <= acc_q + ACC_W'(plo_q);
            end
            PH_SUM: begin
              acc_q  <= acc_new;
              wsum_q <= wsum_new;
              ph_q   <= '0;
              j_q    <= j_q + OCT_IDX_W'(1);
              if (oct_last) begin
                state_q <= ST_DIV;
                rem_q   <= acc_new;
                dsr_q   <= ACC_W'(wsum_new) << (NOISE_W - 1);
                cnt_q   <= QCNT_W'(NOISE_W - 1);
              end
            end
            default: ;
          endcase
        end

        // restoring division of the weighted sum by the weight sum
        ST_DIV: begin
          if (qfit) begin
            rem_q <= rem_q - dsr_q;
          end
          qt_q  <= {qt_q[NOISE_W-2:0], qfit};
          dsr_q <= dsr_q >> 1;
          cnt_q <= cnt_q - QCNT_W'(1);
          if (cnt_q == '0) begin
            state_q <= ST_OUT;
          end
        end

        // hand the result to the output register
        ST_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            noise_q     <= qt_q;
            state_q     <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/octave_value_noise_2d_unit.sv =====
// Multi-octave 2D value noise unit: top level.
// Depends on ovn_pkg, ovn_front, ovn_fifo, ovn_back and ovn_ram.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item per transfer.
//   req_type_i = 0 writes seed_value_i into the seed store at (coord_x_i,
//   coord_y_i) and produces no result; req_type_i = 1 queries the noise at
//   that point and produces one noise_value_o on the output channel
//   (out_valid_o / out_stall_i). Items are processed strictly in order.
//   Configuration (octave count, bias) is written through cfg_we_i, cfg_idx_i and
//   cfg_wdata_i, by the user only while the unit is idle; the block does not enforce it.
// Operation:
//   A write is done as the back end pops it from the queue. A query holds the
//   back end through the four corner reads through the single read port and the
//   split weight multiply per octave, and the 16-step division. The first query
//   after reset or after a bias write first rebuilds the weight table.
// Reset clears the queue, the control state and the weight table valid flag;
//   the seed store is undefined until written. A stalled result holds in the
//   output register; the back end then waits and the 2-entry queue fills up.
`default_nettype none

module octave_value_noise_2d_unit import ovn_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  req_type_i,
  input  logic [COORD_W-1:0]    coord_x_i,
  input  logic [COORD_W-1:0]    coord_y_i,
  input  logic [SEED_W-1:0]     seed_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [NOISE_W-1:0]    noise_value_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic              push;
  item_t             item;
  logic              full;
  logic              empty;
  logic              pop;
  item_t             head;
  cfg_t              cfg;
  ram_req_t          ram_req;
  logic [SEED_W-1:0] ram_rdata;

  ovn_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .seed_value_i (seed_value_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .full_i       (full),
    .push_o       (push),
    .item_o       (item),
    .cfg_o        (cfg)
  );

  ovn_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  ovn_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head),
    .pop_o         (pop),
    .cfg_i         (cfg),
    .ram_o         (ram_req),
    .rdata_i       (ram_rdata),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .noise_value_o (noise_value_o)
  );

  // seed store
  ovn_ram #(
    .WIDTH (SEED_W),
    .DEPTH (STORE_DEPTH)
  ) u_seed_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== sv/ovn_checker.sv =====
// Port-level checker for the noise unit, bound to the top level.
// Depends on ovn_pkg and octave_value_noise_2d_unit_assert.svh.
`default_nettype none

`include "octave_value_noise_2d_unit_assert.svh"

module ovn_checker import ovn_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  req_type_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [NOISE_W-1:0]    noise_value_o
);

  // queue entries, one item in the back end, one in the output register
  localparam int PEND_MAX = FIFO_DEPTH + 2;
  localparam int PEND_W   = $clog2(PEND_MAX + 2);

  logic [PEND_W-1:0] pend_q;
  logic              q_xfer;
  logic              r_xfer;

  assign q_xfer = in_valid_i && !in_stall_o && req_type_i;
  assign r_xfer = out_valid_o && !out_stall_i;

  // queries accepted and not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (q_xfer && !r_xfer) begin
      pend_q <= pend_q + PEND_W'(1);
    end else if (r_xfer && !q_xfer) begin
      pend_q <= pend_q - PEND_W'(1);
    end
  end

  `OVN_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(noise_value_o))
  `OVN_ASSERT_IMPL(a_out_has_query, out_valid_o, pend_q != '0)
  `OVN_ASSERT_IMPL(a_pend_bound, 1'b1, pend_q <= PEND_W'(PEND_MAX))

endmodule

bind octave_value_noise_2d_unit ovn_checker u_ovn_checker (.*);

`default_nettype wire
